### hdl/mlp_pkg.sv
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types and constants of the perceptron evaluator: weight table
// geometry, tanh polynomial coefficients, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mlp_pkg;

	localparam int MAT_LAYERS = 3;
	localparam int MAT_ROWS   = 8;
	localparam int MAT_COLS   = 9;
	localparam int WMEM_DEPTH = MAT_LAYERS * MAT_ROWS * MAT_COLS;
	localparam int WADDR_W    = $clog2(WMEM_DEPTH);
	// row and column counters, wide enough for 32 neurons plus the bias column
	localparam int IDX_W      = 6;

	localparam logic signed [15:0] ONE_Q12   = 16'sd4096;
	localparam logic [16:0]        TANH_HIGH = 17'd21709;
	localparam logic [16:0]        TANH_LOW  = 17'd3686;

	// Q0.16 coefficients
	localparam logic signed [23:0] CUBIC_K3 = -24'sd15453;
	localparam logic signed [23:0] CUBIC_K1 = 24'sd64448;
	localparam logic signed [23:0] QUINT_K5 = 24'sd92;

	function automatic logic signed [23:0] quint_coef(input logic [2:0] step);
		logic signed [23:0] c;
		case (step)
			3'd0:    c = -24'sd1789;
			3'd1:    c = 24'sd13389;
			3'd2:    c = -24'sd49801;
			3'd3:    c = 24'sd92923;
			3'd4:    c = -24'sd4889;
			default: c = 24'sd0;
		endcase
		return c;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE, ST_MAC, ST_DRAIN, ST_ROUND, ST_TSTART, ST_TANH, ST_OMUL, ST_OFIN
	} state_t;

	typedef enum logic [1:0] {PH_L1, PH_L2, PH_OUT} phase_t;

	typedef enum logic [1:0] {SRC_IN, SRC_H1, SRC_H2} src_t;

	typedef struct packed {
		logic             idle;
		logic             load_in;
		logic             wr_en;
		logic             mac_issue;
		logic [1:0]       mat;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		src_t             src;
		logic             round_en;
		logic             tanh_start;
		logic             h1_wr;
		logic             h2_wr;
		logic             out_mul;
		logic             out_fin;
	} mlp_cmd_t;

	typedef struct packed {
		logic tanh_done;
		logic out_full;
	} mlp_status_t;

endpackage

### hdl/mlp_tanh.sv
// ----------------------------------------------------------------------------
// mlp_tanh
// Iterative piecewise tanh in Q3.12: saturation, cubic near zero, quintic
// by Horner steps otherwise; one shared multiplier, one step per cycle.
// ----------------------------------------------------------------------------
module mlp_tanh (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] x,
	output logic               done,
	output logic signed [15:0] y
);
	import mlp_pkg::*;

	logic               busy_q, cub_q, neg_q, done_q;
	logic [2:0]         step_q;
	logic signed [23:0] a_q, acc_q;
	logic signed [15:0] y_q;

	logic [16:0]        ax;
	logic signed [23:0] m1, m2, r12, coef, yv, ylim;
	logic signed [47:0] p, p12, p16;
	logic signed [23:0] acc4;
	logic               last_step;

	assign ax = x[15] ? 17'(-{x[15], x}) : {1'b0, x};

	always_comb begin
		m1   = (cub_q && step_q == 3'd1) ? CUBIC_K3 : acc_q;
		m2   = (cub_q && step_q == 3'd1) ? acc_q : a_q;
		p    = m1 * m2;
		p12  = (p + 48'sd2048) >>> 12;
		p16  = (p + 48'sd32768) >>> 16;
		r12  = p12[23:0];
		coef = cub_q ? ((step_q == 3'd1) ? CUBIC_K1 : 24'sd0) : quint_coef(step_q);
		acc4 = (acc_q + 24'sd8) >>> 4;
		last_step = cub_q ? (step_q == 3'd2) : (step_q == 3'd5);
		yv   = cub_q ? p16[23:0] : acc4;
		if (yv > 24'sd4096)
			ylim = 24'sd4096;
		else if (yv < -24'sd4096)
			ylim = -24'sd4096;
		else
			ylim = yv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (ax >= TANH_HIGH) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= 3'd0;
				end
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= x[15];
			a_q   <= 24'(ax);
			cub_q <= ax <= TANH_LOW;
			acc_q <= (ax <= TANH_LOW) ? 24'(ax) : QUINT_K5;
			y_q   <= x[15] ? -ONE_Q12 : ONE_Q12;
		end else if (busy_q) begin
			if (last_step)
				y_q <= neg_q ? 16'(-ylim) : 16'(ylim);
			else
				acc_q <= r12 + coef;
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

### hdl/mlp_ctrl.sv
// ----------------------------------------------------------------------------
// mlp_ctrl
// Sequencer of the evaluator: walks layers, neurons and columns, and
// steps the datapath through accumulate, round, tanh and output scaling.
// ----------------------------------------------------------------------------
module mlp_ctrl #(
	parameter int HIDDEN_ONE_SIZE = 8,
	parameter int HIDDEN_TWO_SIZE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_accept,
	input  logic                 in_command,
	input  logic [1:0]           layer_count,
	input  mlp_pkg::mlp_status_t st,
	output mlp_pkg::mlp_cmd_t    cmd
);
	import mlp_pkg::*;

	localparam logic [IDX_W-1:0] H1_N = IDX_W'(HIDDEN_ONE_SIZE);
	localparam logic [IDX_W-1:0] H2_N = IDX_W'(HIDDEN_TWO_SIZE);

	state_t           state_q, state_d;
	phase_t           ph_q, ph_d;
	logic [IDX_W-1:0] row_q, row_d, col_q, col_d;
	logic [IDX_W-1:0] ncols, row_last;
	logic             two;

	assign two = layer_count >= 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_L1;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		row_d   = row_q;
		col_d   = col_q;
		cmd     = '0;
		cmd.row = row_q;
		cmd.col = col_q;

		case (ph_q)
			PH_L1: begin
				ncols    = IDX_W'(2);
				row_last = H1_N - IDX_W'(1);
				cmd.mat  = 2'd0;
				cmd.src  = SRC_IN;
			end
			PH_L2: begin
				ncols    = H1_N;
				row_last = H2_N - IDX_W'(1);
				cmd.mat  = 2'd1;
				cmd.src  = SRC_H1;
			end
			default: begin
				ncols    = two ? H2_N : H1_N;
				row_last = '0;
				cmd.mat  = two ? 2'd2 : 2'd1;
				cmd.src  = two ? SRC_H2 : SRC_H1;
			end
		endcase

		case (state_q)
			ST_IDLE: begin
				cmd.idle = 1'b1;
				if (in_accept) begin
					if (in_command) begin
						cmd.load_in = 1'b1;
						ph_d    = PH_L1;
						row_d   = '0;
						col_d   = '0;
						state_d = ST_MAC;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				if (col_q == ncols)
					state_d = ST_DRAIN;
				else
					col_d = col_q + IDX_W'(1);
			end
			ST_DRAIN: state_d = ST_ROUND;
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				state_d = (ph_q == PH_OUT) ? ST_OMUL : ST_TSTART;
			end
			ST_TSTART: begin
				cmd.tanh_start = 1'b1;
				state_d = ST_TANH;
			end
			ST_TANH: begin
				if (st.tanh_done) begin
					cmd.h1_wr = ph_q == PH_L1;
					cmd.h2_wr = ph_q == PH_L2;
					col_d     = '0;
					state_d   = ST_MAC;
					if (row_q == row_last) begin
						row_d = '0;
						ph_d  = (ph_q == PH_L1 && two) ? PH_L2 : PH_OUT;
					end else begin
						row_d = row_q + IDX_W'(1);
					end
				end
			end
			ST_OMUL: begin
				cmd.out_mul = 1'b1;
				state_d = ST_OFIN;
			end
			ST_OFIN: begin
				if (!st.out_full) begin
					cmd.out_fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hdl/mlp_dp.sv
// ----------------------------------------------------------------------------
// mlp_dp
// Datapath: weight memory, hidden value registers, multiply-accumulate,
// Q3.12 rounding with clip, output offset and span scaling, result register.
// ----------------------------------------------------------------------------
module mlp_dp #(
	parameter int HIDDEN_ONE_SIZE = 8,
	parameter int HIDDEN_TWO_SIZE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mlp_pkg::mlp_cmd_t  cmd,
	input  logic [1:0]         in_layer,
	input  logic [2:0]         in_row,
	input  logic [3:0]         in_col,
	input  logic signed [15:0] in_weight,
	input  logic signed [15:0] in_lux,
	input  logic signed [15:0] in_temp,
	input  logic signed [15:0] out_offset,
	input  logic [15:0]        out_span,
	input  logic signed [15:0] tanh_y,
	output logic signed [15:0] tanh_x,
	output logic               out_full,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [31:0] voltage_ref,
	output logic               saturated
);
	import mlp_pkg::*;

	localparam int H1_IW = (HIDDEN_ONE_SIZE > 1) ? $clog2(HIDDEN_ONE_SIZE) : 1;
	localparam int H2_IW = (HIDDEN_TWO_SIZE > 1) ? $clog2(HIDDEN_TWO_SIZE) : 1;

	logic signed [15:0] wmem [WMEM_DEPTH];
	logic signed [15:0] h1_q [HIDDEN_ONE_SIZE];
	logic signed [15:0] h2_q [HIDDEN_TWO_SIZE];

	logic [WADDR_W-1:0] wr_addr, rd_addr;
	logic               rd_ok;
	logic [IDX_W-1:0]   col_m1;
	logic signed [15:0] opnd, rdata_q, opnd_s1, lux_q, temp_q, q12_q;
	logic               mac_s1, first_s1, zero_s1;
	logic signed [39:0] acc_q, prod_ext, rnd;
	logic signed [31:0] prod;
	logic               clip_q, out_v_q;
	logic signed [16:0] sum17;
	logic signed [33:0] oprod_q, orv;
	logic signed [31:0] volt_q;
	logic               sat_q;

	assign wr_addr = WADDR_W'(in_layer) * WADDR_W'(MAT_ROWS * MAT_COLS)
		+ WADDR_W'(in_row) * WADDR_W'(MAT_COLS) + WADDR_W'(in_col);
	assign rd_addr = WADDR_W'(cmd.mat) * WADDR_W'(MAT_ROWS * MAT_COLS)
		+ WADDR_W'(cmd.row[2:0]) * WADDR_W'(MAT_COLS) + WADDR_W'(cmd.col[3:0]);
	// neurons and columns outside the 8 x 9 table use weight zero
	assign rd_ok = (cmd.row < IDX_W'(MAT_ROWS)) && (cmd.col < IDX_W'(MAT_COLS));
	assign col_m1 = cmd.col - IDX_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && in_layer < 2'(MAT_LAYERS) && in_col < 4'(MAT_COLS))
			wmem[wr_addr] <= in_weight;
		if (cmd.mac_issue)
			rdata_q <= wmem[rd_addr];
	end

	always_comb begin
		if (cmd.col == '0) begin
			opnd = ONE_Q12;
		end else begin
			case (cmd.src)
				SRC_IN:  opnd = (cmd.col == IDX_W'(1)) ? lux_q :
					(cmd.col == IDX_W'(2)) ? temp_q : 16'sd0;
				SRC_H1:  opnd = h1_q[col_m1[H1_IW-1:0]];
				SRC_H2:  opnd = h2_q[col_m1[H2_IW-1:0]];
				default: opnd = 16'sd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1   <= 1'b0;
			first_s1 <= 1'b0;
			zero_s1  <= 1'b0;
		end else begin
			mac_s1   <= cmd.mac_issue;
			first_s1 <= cmd.col == '0;
			zero_s1  <= !rd_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_issue)
			opnd_s1 <= opnd;
		if (cmd.load_in) begin
			lux_q  <= in_lux;
			temp_q <= in_temp;
		end
	end

	assign prod     = rdata_q * opnd_s1;
	assign prod_ext = zero_s1 ? 40'sd0 : {{8{prod[31]}}, prod};
	assign rnd      = (acc_q + 40'sd2048) >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else begin
			if (mac_s1)
				acc_q <= first_s1 ? prod_ext : acc_q + prod_ext;
			if (cmd.load_in)
				clip_q <= 1'b0;
			else if (cmd.round_en && (rnd > 40'sd32767 || rnd < -40'sd32768))
				clip_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			if (rnd > 40'sd32767)
				q12_q <= 16'sd32767;
			else if (rnd < -40'sd32768)
				q12_q <= -16'sd32768;
			else
				q12_q <= rnd[15:0];
		end
		if (cmd.h1_wr)
			h1_q[cmd.row[H1_IW-1:0]] <= tanh_y;
		if (cmd.h2_wr)
			h2_q[cmd.row[H2_IW-1:0]] <= tanh_y;
	end

	assign tanh_x = q12_q;

	// (y + offset) * span stays within 34 bits, so the 32-bit result never clips
	assign sum17 = 17'(q12_q) + 17'(out_offset);
	assign orv   = oprod_q + 34'sd128;

	always_ff @(posedge clk) begin
		if (cmd.out_mul)
			oprod_q <= sum17 * $signed({1'b0, out_span});
		if (cmd.out_fin) begin
			volt_q <= {{6{orv[33]}}, orv[33:8]};
			sat_q  <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.out_fin)
			out_v_q <= 1'b1;
		else if (out_ready)
			out_v_q <= 1'b0;
	end

	assign out_full    = out_v_q && !out_ready;
	assign out_valid   = out_v_q;
	assign voltage_ref = volt_q;
	assign saturated   = sat_q;

endmodule

### hdl/mlp_inference_tanh_approx.sv
// ----------------------------------------------------------------------------
// mlp_inference_tanh_approx
// Small perceptron evaluator with piecewise tanh hidden layers.
// ----------------------------------------------------------------------------
// A weight write (tuser 0) gives no result. An inference (tuser 1) runs
// serially through one multiply-accumulate unit fed by the weight memory:
// each neuron accumulates its sources and the bias, then drains and rounds;
// each hidden neuron then goes through tanh start and iteration (saturated,
// cubic or quintic), and the output neuron through the output scaling. The
// input is not taken again until the result is in the output register; the
// result then waits there while the next item is accepted.
// ----------------------------------------------------------------------------
module mlp_inference_tanh_approx #(
	parameter int HIDDEN_ONE_SIZE = 8,
	parameter int HIDDEN_TWO_SIZE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// layer_select[1:0], neuron_row[4:2], weight_col[8:5], weight_value[24:9],
	// lux_norm[40:25], temp_norm[56:41], zero fill above
	input  logic [63:0] s_axis_tdata,
	// command[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// voltage_ref[31:0]
	output logic [31:0] m_axis_tdata,
	// saturated[0]
	output logic        m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mlp_pkg::*;

	localparam logic [1:0] REG_LAYER_COUNT = 2'd0;
	localparam logic [1:0] REG_OUT_OFFSET  = 2'd1;
	localparam logic [1:0] REG_OUT_SPAN    = 2'd2;

	logic [1:0]         layer_count_q;
	logic signed [15:0] out_offset_q;
	logic [15:0]        out_span_q;
	mlp_cmd_t           cmd;
	mlp_status_t        st;
	logic               in_accept, tanh_done, out_full;
	logic signed [15:0] tanh_x, tanh_y;
	logic signed [31:0] volt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= 2'd2;
			out_offset_q  <= 16'sd0;
			out_span_q    <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LAYER_COUNT: layer_count_q <= cfg_data[1:0];
				REG_OUT_OFFSET:  out_offset_q  <= cfg_data;
				REG_OUT_SPAN:    out_span_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = cmd.idle;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign st.tanh_done  = tanh_done;
	assign st.out_full   = out_full;

	mlp_ctrl #(
		.HIDDEN_ONE_SIZE(HIDDEN_ONE_SIZE),
		.HIDDEN_TWO_SIZE(HIDDEN_TWO_SIZE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.in_command (s_axis_tuser),
		.layer_count(layer_count_q),
		.st         (st),
		.cmd        (cmd)
	);

	mlp_dp #(
		.HIDDEN_ONE_SIZE(HIDDEN_ONE_SIZE),
		.HIDDEN_TWO_SIZE(HIDDEN_TWO_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_layer   (s_axis_tdata[1:0]),
		.in_row     (s_axis_tdata[4:2]),
		.in_col     (s_axis_tdata[8:5]),
		.in_weight  (s_axis_tdata[24:9]),
		.in_lux     (s_axis_tdata[40:25]),
		.in_temp    (s_axis_tdata[56:41]),
		.out_offset (out_offset_q),
		.out_span   (out_span_q),
		.tanh_y     (tanh_y),
		.tanh_x     (tanh_x),
		.out_full   (out_full),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.voltage_ref(volt),
		.saturated  (m_axis_tuser)
	);

	mlp_tanh u_tanh (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.tanh_start),
		.x     (tanh_x),
		.done  (tanh_done),
		.y     (tanh_y)
	);

	assign m_axis_tdata = volt;

	// a new result only comes out of a busy block
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared while block was idle");

	// tanh finishes only during an inference
	a_tanh_in_infer: assert property (@(posedge clk) disable iff (!arst_n)
		tanh_done |-> !s_axis_tready)
		else $error("tanh completion while idle");

	// an inference transaction blocks further input
	a_infer_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
		else $error("input accepted during inference");

endmodule

### tb/mlp_inference_tanh_approx_tb.sv
// ----------------------------------------------------------------------------
// mlp_inference_tanh_approx_tb
// Self-checking bench for the perceptron evaluator: loads weight tables,
// runs inferences under several output settings and layer counts, and
// compares every voltage result and clip flag against a bit-exact predictor.
// ----------------------------------------------------------------------------
module mlp_inference_tanh_approx_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mlp_pkg::*;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_INFER = 1'b1;
	localparam logic [1:0] REG_LAYERS = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_SPAN   = 2'd2;
	localparam int N_RANDOM = 1350;

	typedef struct {
		logic [31:0] volts;
		logic        clip;
	} volt_result_t;

	// predictor of the evaluator plus the queue of voltages still due
	class volt_scoreboard;
		logic signed [15:0] weights [MAT_LAYERS*MAT_ROWS*MAT_COLS];
		logic [1:0]         n_layers;
		longint             offset;
		longint             span;
		volt_result_t       due [$];
		int                 n_bad;

		function new();
			foreach (weights[i]) weights[i] = '0;
			n_layers = 2;
			offset = 0;
			span = 256;
			n_bad = 0;
		endfunction

		function longint rnd_shift(longint v, int s);
			longint t;
			t = v + (longint'(1) <<< (s - 1));
			return t >>> s;
		endfunction

		function longint w_at(int l, int r, int c);
			return longint'(weights[(l*MAT_ROWS + r)*MAT_COLS + c]);
		endfunction

		function longint to_q12(longint acc, ref bit clip);
			longint r;
			r = rnd_shift(acc, 12);
			if (r > 32767) begin clip = 1; return 32767; end
			if (r < -32768) begin clip = 1; return -32768; end
			return r;
		endfunction

		function longint tanh_fx(longint x);
			longint a, y, acc, sq;
			a = (x < 0) ? -x : x;
			if (a >= 21709) begin
				y = 4096;
			end else if (a <= 3686) begin
				sq = rnd_shift(a*a, 12);
				acc = rnd_shift(-15453*sq, 12) + 64448;
				y = rnd_shift(acc*a, 16);
			end else begin
				acc = 92;
				acc = rnd_shift(acc*a, 12) - 1789;
				acc = rnd_shift(acc*a, 12) + 13389;
				acc = rnd_shift(acc*a, 12) - 49801;
				acc = rnd_shift(acc*a, 12) + 92923;
				acc = rnd_shift(acc*a, 12) - 4889;
				y = rnd_shift(acc, 4);
			end
			if (y > 4096) y = 4096;
			if (y < -4096) y = -4096;
			return (x < 0) ? -y : y;
		endfunction

		function longint neuron(int l, int r, longint prev [8], int cnt, ref bit clip);
			longint acc;
			acc = w_at(l, r, 0) * 4096;
			for (int k = 0; k < cnt; k++) acc += w_at(l, r, k+1) * prev[k];
			return to_q12(acc, clip);
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] d);
			case (idx)
				REG_LAYERS: n_layers = d[1:0];
				REG_OFFSET: offset = longint'($signed(d));
				REG_SPAN:   span = longint'(d);
				default: ;
			endcase
		endfunction

		function void note_item(logic cmd, logic [63:0] d);
			longint xv [8], h1 [8], h2 [8];
			longint y, v;
			bit clip;
			volt_result_t res;
			if (cmd == CMD_LOAD) begin
				if (d[1:0] < MAT_LAYERS && d[8:5] < MAT_COLS)
					weights[(d[1:0]*MAT_ROWS + d[4:2])*MAT_COLS + d[8:5]] = d[24:9];
				return;
			end
			clip = 0;
			foreach (xv[i]) xv[i] = 0;
			xv[0] = longint'($signed(d[40:25]));
			xv[1] = longint'($signed(d[56:41]));
			for (int i = 0; i < 8; i++) h1[i] = tanh_fx(neuron(0, i, xv, 2, clip));
			if (n_layers >= 2) begin
				for (int i = 0; i < 8; i++) h2[i] = tanh_fx(neuron(1, i, h1, 8, clip));
				y = neuron(2, 0, h2, 8, clip);
			end else begin
				y = neuron(1, 0, h1, 8, clip);
			end
			v = rnd_shift((y + offset) * span, 8);
			if (v > 64'sd2147483647) begin v = 64'sd2147483647; clip = 1; end
			if (v < -64'sd2147483648) begin v = -64'sd2147483648; clip = 1; end
			res.volts = v[31:0];
			res.clip = clip;
			due.push_back(res);
		endfunction

		function void check(logic [31:0] volts, logic clip);
			volt_result_t e;
			if (due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result %h clip %b", volts, clip);
				return;
			end
			e = due.pop_front();
			if (e.volts !== volts || e.clip !== clip) begin
				n_bad++;
				if (n_bad <= 10)
					$display("mismatch: expected %h clip %b, got %h clip %b",
						e.volts, e.clip, volts, clip);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	volt_scoreboard sb = new();
	int  rx_hold;
	bit  rx_on;

	mlp_inference_tanh_approx i_dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// short gaps mostly, now and then a long one
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// tvalid stays high after a transaction until the next one or a drain
	task automatic send_item(logic cmd, logic [63:0] d);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(cmd, d);
		@(negedge clk);
	endtask

	task automatic load_w(int l, int r, int c, logic [15:0] w);
		logic [63:0] d;
		d = '0;
		d[1:0] = 2'(l); d[4:2] = 3'(r); d[8:5] = 4'(c); d[24:9] = w;
		send_item(CMD_LOAD, d);
	endtask

	task automatic infer(logic [15:0] lux, logic [15:0] tmp);
		logic [63:0] d;
		d = {$urandom, $urandom};
		d[63:57] = '0;
		d[40:25] = lux; d[56:41] = tmp;
		send_item(CMD_INFER, d);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		// a trailing weight write may still be in flight
		repeat (20) @(posedge clk);
	endtask

	// weight draws: mostly moderate so tanh spans all three pieces
	function logic [15:0] rand_w();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	task automatic fill_table();
		for (int l = 0; l < MAT_LAYERS; l++)
			for (int r = 0; r < MAT_ROWS; r++)
				for (int c = 0; c < MAT_COLS; c++) load_w(l, r, c, rand_w());
	endtask

	function logic [15:0] rand_in();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return 16'($urandom);
		return 16'($signed($urandom_range(0, 16384)) - 8192);
	endfunction

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!rx_on) begin
			m_axis_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		#20ms;
		$display("mlp_inference_tanh_approx_tb: FAIL");
		$finish;
	end

	initial begin
		logic [15:0] span_set [4];
		logic [15:0] off_set [4];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_axis_tready = 1'b0;
		rx_on = 1'b0;
		rx_hold = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		rx_on = 1'b1;

		// directed: every weight written first, then extremes
		fill_table();
		load_w(3, 0, 0, 16'h7fff);
		load_w(0, 7, 15, 16'h8000);
		load_w(1, 7, 8, 16'h7fff);
		load_w(0, 7, 1, 16'h8000);
		infer(16'h7fff, 16'h8000);
		infer(16'h8000, 16'h7fff);
		infer(16'h0000, 16'h0000);
		infer(16'h0e66, 16'hf19a);
		infer(16'h54cd, 16'hab33);
		drain();
		write_reg(REG_LAYERS, 16'd1);
		write_reg(REG_OFFSET, 16'h7fff);
		write_reg(REG_SPAN, 16'hffff);
		infer(16'h7fff, 16'h7fff);
		infer(16'h8000, 16'h8000);
		drain();
		write_reg(REG_LAYERS, 16'd0);
		write_reg(REG_OFFSET, 16'h8000);
		infer(16'h1234, 16'hedcb);
		drain();
		write_reg(REG_LAYERS, 16'd3);
		write_reg(REG_SPAN, 16'h0000);
		infer(16'h7fff, 16'h0100);
		drain();

		span_set[0] = 16'd256; span_set[1] = 16'hffff;
		span_set[2] = 16'd0;   span_set[3] = 16'd1000;
		off_set[0] = 16'd0;     off_set[1] = 16'h7fff;
		off_set[2] = 16'h8000;  off_set[3] = 16'hfc00;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_LAYERS, 16'($urandom_range(0, 3)));
			write_reg(REG_OFFSET, (ph < 4) ? off_set[ph] : 16'($urandom));
			write_reg(REG_SPAN, (ph < 4) ? span_set[ph] : 16'($urandom));
			if (ph == 2) rx_hold = 400;
			for (int n = 0; n < N_RANDOM / 6; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					logic [63:0] d;
					d = {$urandom, $urandom};
					d[63:57] = '0;
					send_item(CMD_LOAD, d);
				end else begin
					infer(rand_in(), rand_in());
				end
			end
			drain();
		end

		if (sb.n_bad == 0 && sb.due.size() == 0) begin
			$display("mlp_inference_tanh_approx_tb: PASS");
		end else begin
			$display("mlp_inference_tanh_approx_tb: FAIL");
		end
		$finish;
	end

endmodule
